>>> hw/rtl/bidirectional_flow_counter_table_unit_defines.svh
// assertion macros for the flow table
`ifndef BIDIRECTIONAL_FLOW_COUNTER_TABLE_UNIT_DEFINES_SVH
`define BIDIRECTIONAL_FLOW_COUNTER_TABLE_UNIT_DEFINES_SVH

// implication checked at every clock edge outside reset
`define BFC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// condition checked in the cycle after the antecedent
`define BFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/bfc_pkg.sv
package bfc_pkg;

  localparam int unsigned MODE_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_UPDATE = 2'd0,
    MODE_CLEAR  = 2'd1,
    MODE_READ   = 2'd2,
    MODE_NONE   = 2'd3
  } bfc_mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_CHECK,
    ST_UPDATE,
    ST_READ,
    ST_DONE
  } bfc_state_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [31:0] frame_count;
    logic [31:0] byte_count;
    logic [7:0]  read_index;
  } bfc_req_t;

  typedef struct packed {
    logic [7:0]  entry_index;
    logic        is_new;
    logic        table_full;
    logic        entry_valid;
    logic [31:0] first_addr;
    logic [31:0] second_addr;
    logic [15:0] first_port;
    logic [15:0] second_port;
    logic [31:0] fwd_frames;
    logic [31:0] fwd_bytes;
    logic [31:0] rev_frames;
    logic [31:0] rev_bytes;
  } bfc_rsp_t;

  typedef struct packed {
    logic [31:0] fwd_frames;
    logic [31:0] fwd_bytes;
    logic [31:0] rev_frames;
    logic [31:0] rev_bytes;
  } bfc_cnt_t;

endpackage

>>> hw/rtl/bidirectional_flow_counter_table_unit.sv
// update: the stored entries are scanned one per cycle (0 to MAX_FLOWS of them) until
// a hit or the last entry, then the hit entry is updated or a new one appended; read,
// clear and unused mode take no scan. one request at a time, busy_o high until the result
// cycle ends; the next request can be taken in the cycle after done_o
// result is valid for one cycle with done_o; the receiver cannot stall
// reset empties the table at once (entry count to zero), no clearing pass
module bidirectional_flow_counter_table_unit import bfc_pkg::*; #(
  parameter int unsigned MAX_FLOWS = 256,
  parameter int unsigned ADDR_BITS = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  bfc_req_t req_i,
  output logic     busy_o,
  output logic     done_o,
  output bfc_rsp_t rsp_o
);
`include "bidirectional_flow_counter_table_unit_defines.svh"

  localparam int unsigned IDX_W = (MAX_FLOWS > 1) ? $clog2(MAX_FLOWS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_FLOWS + 1);
  localparam int unsigned AW    = ADDR_BITS;
  localparam int unsigned KEY_W = 2 * AW + 32;

  bfc_state_e state_q, state_d;
  bfc_req_t   req_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] scan_q, scan_d;
  logic [AW-1:0] a1_q, a2_q;
  logic [15:0]   p1_q, p2_q;
  logic          keep_q;
  logic          fresh_q;
  logic [IDX_W-1:0] hit_q;
  bfc_rsp_t      rsp_q, rsp_d;
  logic          done_q;

  logic             key_we, cnt_we;
  logic [IDX_W-1:0] key_waddr, key_raddr, cnt_raddr, cnt_waddr;
  logic [KEY_W-1:0] key_wdata, key_rdata;
  bfc_cnt_t         cnt_wdata, cnt_rdata;

  bfc_key_mem #(.DEPTH(MAX_FLOWS), .AW(AW), .IDX_W(IDX_W)) u_key (
    .clk_i, .we_i(key_we), .waddr_i(key_waddr), .wdata_i(key_wdata),
    .raddr_i(key_raddr), .rdata_o(key_rdata)
  );
  bfc_cnt_mem #(.DEPTH(MAX_FLOWS), .IDX_W(IDX_W)) u_cnt (
    .clk_i, .we_i(cnt_we), .waddr_i(cnt_waddr), .wdata_i(cnt_wdata),
    .raddr_i(cnt_raddr), .rdata_o(cnt_rdata)
  );

  // canonical ordering of the incoming sample
  logic [AW-1:0] src_in, dst_in;
  logic          keep_in;
  assign src_in  = AW'(req_i.src_addr);
  assign dst_in  = AW'(req_i.dst_addr);
  assign keep_in = (src_in < dst_in) ||
                   ((src_in == dst_in) && (req_i.sport > req_i.dport));

  // key memory fields
  logic [AW-1:0] k_a1, k_a2;
  logic [15:0]   k_p1, k_p2;
  assign k_a1 = key_rdata[KEY_W-1 -: AW];
  assign k_a2 = key_rdata[32 +: AW];
  assign k_p1 = key_rdata[31:16];
  assign k_p2 = key_rdata[15:0];

  logic fwd_hit, rev_hit;
  assign fwd_hit = (k_a1 == a1_q) && (k_a2 == a2_q) && (k_p1 == p1_q) && (k_p2 == p2_q);
  assign rev_hit = (k_a1 == a2_q) && (k_a2 == a1_q) && (k_p1 == p2_q) && (k_p2 == p1_q);

  // tx when the sample matches the canonical order exactly
  logic to_tx;
  assign to_tx = keep_q ||
                 ((AW'(req_q.src_addr) == AW'(req_q.dst_addr)) &&
                  (req_q.sport == req_q.dport));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (req_i.mode)
            MODE_UPDATE: state_d = (count_q == '0) ? ST_CHECK : ST_SEARCH;
            MODE_READ:   state_d = ST_READ;
            default:     state_d = ST_DONE;
          endcase
        end
      end
      ST_SEARCH: begin
        if (fwd_hit || rev_hit) state_d = ST_UPDATE;
        else if (scan_q == count_q) state_d = ST_CHECK;
      end
      ST_CHECK:  state_d = ST_DONE;
      ST_UPDATE: state_d = ST_DONE;
      ST_READ:   state_d = ST_DONE;
      ST_DONE:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    count_d   = count_q;
    scan_d    = scan_q;
    key_we    = 1'b0;
    cnt_we    = 1'b0;
    key_waddr = count_q[IDX_W-1:0];
    key_wdata = {a1_q, a2_q, p1_q, p2_q};
    key_raddr = scan_q[IDX_W-1:0];
    cnt_raddr = hit_q;
    cnt_waddr = hit_q;
    cnt_wdata = cnt_rdata;
    rsp_d     = '0;
    case (state_q)
      ST_IDLE: begin
        key_raddr = '0;
        cnt_raddr = IDX_W'(req_i.read_index);
        scan_d    = CNT_W'(1);
        if (start_i && (req_i.mode == MODE_CLEAR)) count_d = '0;
      end
      ST_SEARCH: begin
        scan_d = scan_q + CNT_W'(1);
      end
      ST_CHECK: begin
        // miss: append an entry holding the sample's counts in its direction, or report full
        if (count_q >= CNT_W'(MAX_FLOWS)) begin
          rsp_d.table_full = 1'b1;
        end else begin
          key_we  = 1'b1;
          cnt_we  = 1'b1;
          cnt_waddr = count_q[IDX_W-1:0];
          count_d = count_q + CNT_W'(1);
          cnt_wdata = '0;
          if (to_tx) begin
            cnt_wdata.fwd_frames = req_q.frame_count;
            cnt_wdata.fwd_bytes  = req_q.byte_count;
          end else begin
            cnt_wdata.rev_frames = req_q.frame_count;
            cnt_wdata.rev_bytes  = req_q.byte_count;
          end
          rsp_d.entry_index = 8'(count_q);
          rsp_d.is_new      = 1'b1;
          rsp_d.entry_valid = 1'b1;
          rsp_d.first_addr  = 32'(a1_q);
          rsp_d.second_addr = 32'(a2_q);
          rsp_d.first_port  = p1_q;
          rsp_d.second_port = p2_q;
          rsp_d.fwd_frames  = cnt_wdata.fwd_frames;
          rsp_d.fwd_bytes   = cnt_wdata.fwd_bytes;
          rsp_d.rev_frames  = cnt_wdata.rev_frames;
          rsp_d.rev_bytes   = cnt_wdata.rev_bytes;
        end
      end
      ST_UPDATE: begin
        cnt_we = 1'b1;
        if (to_tx) begin
          cnt_wdata.fwd_frames = cnt_rdata.fwd_frames + req_q.frame_count;
          cnt_wdata.fwd_bytes  = cnt_rdata.fwd_bytes + req_q.byte_count;
        end else begin
          cnt_wdata.rev_frames = cnt_rdata.rev_frames + req_q.frame_count;
          cnt_wdata.rev_bytes  = cnt_rdata.rev_bytes + req_q.byte_count;
        end
        // stored keys are canonical, so the hit entry holds the canonical sample
        rsp_d.entry_index = 8'(hit_q);
        rsp_d.entry_valid = 1'b1;
        rsp_d.first_addr  = 32'(a1_q);
        rsp_d.second_addr = 32'(a2_q);
        rsp_d.first_port  = p1_q;
        rsp_d.second_port = p2_q;
        rsp_d.fwd_frames  = cnt_wdata.fwd_frames;
        rsp_d.fwd_bytes   = cnt_wdata.fwd_bytes;
        rsp_d.rev_frames  = cnt_wdata.rev_frames;
        rsp_d.rev_bytes   = cnt_wdata.rev_bytes;
      end
      ST_READ: begin
        if (32'(req_q.read_index) < 32'(count_q)) begin
          rsp_d.entry_index = req_q.read_index;
          rsp_d.entry_valid = 1'b1;
          rsp_d.first_addr  = 32'(k_a1);
          rsp_d.second_addr = 32'(k_a2);
          rsp_d.first_port  = k_p1;
          rsp_d.second_port = k_p2;
          rsp_d.fwd_frames  = cnt_rdata.fwd_frames;
          rsp_d.fwd_bytes   = cnt_rdata.fwd_bytes;
          rsp_d.rev_frames  = cnt_rdata.rev_frames;
          rsp_d.rev_bytes   = cnt_rdata.rev_bytes;
        end
      end
      default: ;
    endcase
    // read index drives key port too on read accept
    if (state_q == ST_IDLE && start_i && req_i.mode == MODE_READ) begin
      key_raddr = IDX_W'(req_i.read_index);
    end
    // hit: fetch counters of the matched entry
    if (state_q == ST_SEARCH) begin
      cnt_raddr = IDX_W'(scan_q - CNT_W'(1));
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= (state_d == ST_DONE);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    scan_q <= scan_d;
    if (state_q == ST_IDLE && start_i) begin
      req_q  <= req_i;
      keep_q <= keep_in;
      a1_q   <= keep_in ? src_in : dst_in;
      a2_q   <= keep_in ? dst_in : src_in;
      p1_q   <= keep_in ? req_i.sport : req_i.dport;
      p2_q   <= keep_in ? req_i.dport : req_i.sport;
    end
    if (state_q == ST_SEARCH) hit_q <= IDX_W'(scan_q - CNT_W'(1));
    if (state_q == ST_CHECK) fresh_q <= 1'b1;
    else if (state_q == ST_IDLE) fresh_q <= 1'b0;
    if (state_d == ST_DONE) rsp_q <= rsp_d;
  end

  // clear and unused mode answer with zeros
  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  always_comb begin
    rsp_o = rsp_q;
    if (fresh_q) rsp_o.is_new = rsp_q.entry_valid;
  end

  `BFC_ASSERT_IMPL(a_cnt_bound, clk_i, rst_ni, 1'b1, count_q <= CNT_W'(MAX_FLOWS))
  `BFC_ASSERT_NEXT(a_done_idle, clk_i, rst_ni, done_o, !busy_o)
  `BFC_ASSERT_IMPL(a_full_only_max, clk_i, rst_ni, done_o && rsp_o.table_full,
                   count_q == CNT_W'(MAX_FLOWS))
endmodule

>>> hw/rtl/bfc_key_mem.sv
module bfc_key_mem import bfc_pkg::*; #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned AW     = 32,
  parameter int unsigned IDX_W  = 8
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [IDX_W-1:0]   waddr_i,
  input  logic [2*AW+31:0]   wdata_i,
  input  logic [IDX_W-1:0]   raddr_i,
  output logic [2*AW+31:0]   rdata_o
);
  logic [2*AW+31:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> hw/rtl/bfc_cnt_mem.sv
module bfc_cnt_mem import bfc_pkg::*; #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned IDX_W = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  bfc_cnt_t         wdata_i,
  input  logic [IDX_W-1:0] raddr_i,
  output bfc_cnt_t         rdata_o
);
  bfc_cnt_t mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end
endmodule
